// File: sv/efog_pkg.sv
// Shared constants, codes and functions for the ego frame offset goal generator.
// No dependencies; used by efog_cordic and the top level.
package efog_pkg;

	localparam int CORDIC_STEPS = 15;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int XW           = 34;
	localparam int ZW           = 18;
	localparam int TW           = 31;
	localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [XW-1:0] TRIG_ONE    = 34'sd536870912;

	localparam logic REG_PATH_COUNT      = 1'b0;
	localparam logic REG_LATERAL_SPACING = 1'b1;

	localparam logic [4:0]  PATH_COUNT_RESET = 5'd7;
	localparam logic [20:0] SPACING_RESET    = 21'd65536;

	function automatic logic signed [ZW-1:0] atan_unit(input int k);
		logic signed [ZW-1:0] r;
		unique case (k)
			0:  r = 18'sd8192;
			1:  r = 18'sd4836;
			2:  r = 18'sd2555;
			3:  r = 18'sd1297;
			4:  r = 18'sd651;
			5:  r = 18'sd326;
			6:  r = 18'sd163;
			7:  r = 18'sd81;
			8:  r = 18'sd41;
			9:  r = 18'sd20;
			10: r = 18'sd10;
			11: r = 18'sd5;
			12: r = 18'sd3;
			default: r = 18'sd1;
		endcase
		return r;
	endfunction

endpackage

// File: sv/efog_cordic.sv
// Pipelined sine and cosine of a 16-bit binary angle, one CORDIC step per stage.
// Depends on efog_pkg; every stage register advances only while en is high.
module efog_cordic (
	input  logic                              clk,
	input  logic                              en,
	input  logic [15:0]                       angle,
	output logic signed [efog_pkg::TW-1:0]    cos_o,
	output logic signed [efog_pkg::TW-1:0]    sin_o
);

	localparam int N  = efog_pkg::CORDIC_STEPS;
	localparam int XW = efog_pkg::XW;
	localparam int ZW = efog_pkg::ZW;

	logic signed [XW-1:0] x_q [0:N];
	logic signed [XW-1:0] y_q [0:N];
	logic signed [ZW-1:0] z_q [0:N];
	logic                 f_q [0:N];

	logic [15:0] a_sum, a_fold;
	logic        flip;

	assign a_sum  = angle + 16'h4000;
	assign flip   = a_sum[15];
	assign a_fold = flip ? (angle ^ 16'h8000) : angle;

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= efog_pkg::CORDIC_GAIN;
			y_q[0] <= '0;
			z_q[0] <= ZW'($signed(a_fold));
			f_q[0] <= flip;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic signed [XW-1:0] xs, ys;
		assign xs = y_q[k] >>> k;
		assign ys = x_q[k] >>> k;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[k][ZW-1]) begin
					x_q[k+1] <= x_q[k] - xs;
					y_q[k+1] <= y_q[k] + ys;
					z_q[k+1] <= z_q[k] - efog_pkg::atan_unit(k);
				end else begin
					x_q[k+1] <= x_q[k] + xs;
					y_q[k+1] <= y_q[k] - ys;
					z_q[k+1] <= z_q[k] + efog_pkg::atan_unit(k);
				end
				f_q[k+1] <= f_q[k];
			end
		end
	end

	function automatic logic signed [XW-1:0] fin(input logic signed [XW-1:0] v,
			input logic fl);
		logic signed [XW-1:0] r;
		r = (v + XW'(1)) >>> 1;
		if (r > efog_pkg::TRIG_ONE)
			r = efog_pkg::TRIG_ONE;
		else if (r < -efog_pkg::TRIG_ONE)
			r = -efog_pkg::TRIG_ONE;
		return fl ? -r : r;
	endfunction

	logic signed [XW-1:0] c_full, s_full;
	assign c_full = fin(x_q[N], f_q[N]);
	assign s_full = fin(y_q[N], f_q[N]);

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= c_full[efog_pkg::TW-1:0];
			sin_o <= s_full[efog_pkg::TW-1:0];
		end
	end

endmodule

// File: sv/ego_frame_offset_goal_generator.sv
// Top level: pose transform pipeline and offset goal sequencer.
// Depends on efog_pkg and efog_cordic.
//
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  ego pose and goal pose
// m_*       out        m_tvalid/m_tready  one offset goal, tlast on the final one
// cfg_*     in         cfg_we             path_count, lateral_spacing
//
// An item passes CORDIC_LAT + 2 transform stages and three result stages before its first
// result is valid; its n results then follow one per cycle while the output is not stalled.
// With the pipeline full, a new item is taken as the held item's last result is issued.
// Items with a zero count or zero spacing are taken and give no result.
// Reset clears valid bits, the sequencer and the registers to 7 and 65536.
// A stalled output freezes the result stages; the transform stages run until hold_v is set.
module ego_frame_offset_goal_generator #(
	parameter int MAX_PATHS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ego_x, ego_y, ego_z, ego_heading, goal_x, goal_y, goal_z, goal_heading
	input  logic [223:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// offset_x, offset_y, offset_z, offset_heading, goal_index, zero fill
	output logic [119:0] m_tdata,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [20:0]  cfg_wdata
);

	localparam int L  = efog_pkg::CORDIC_LAT;
	localparam int TW = efog_pkg::TW;
	localparam int IW = $clog2(MAX_PATHS + 1);
	localparam int CW = (IW > 5) ? IW : 5;
	localparam int DW = IW + 1 + 22;
	localparam int PW = 64;
	localparam int AW = 66;

	logic [4:0]  path_count_q;
	logic [20:0] spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_count_q <= efog_pkg::PATH_COUNT_RESET;
			spacing_q    <= efog_pkg::SPACING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efog_pkg::REG_PATH_COUNT:      path_count_q <= cfg_wdata[4:0];
				efog_pkg::REG_LATERAL_SPACING: spacing_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [CW-1:0] pc_w;
	logic [IW-1:0] n_eff, half;
	assign pc_w  = CW'(path_count_q);
	assign n_eff = (pc_w > CW'(MAX_PATHS)) ? IW'(MAX_PATHS) : IW'(path_count_q);
	assign half  = n_eff >> 1;

	logic signed [31:0] ego_x, ego_y, ego_z, goal_x, goal_y, goal_z;
	logic [15:0] ego_h, goal_h, rel, perp;
	assign ego_x  = s_tdata[31:0];
	assign ego_y  = s_tdata[63:32];
	assign ego_z  = s_tdata[95:64];
	assign ego_h  = s_tdata[111:96];
	assign goal_x = s_tdata[143:112];
	assign goal_y = s_tdata[175:144];
	assign goal_z = s_tdata[207:176];
	assign goal_h = s_tdata[223:208];
	assign rel    = goal_h - ego_h;
	assign perp   = rel + 16'h4000;

	logic signed [32:0] dx_in, dy_in, dz_in;
	logic signed [31:0] dz_sat;
	assign dx_in = 33'(goal_x) - 33'(ego_x);
	assign dy_in = 33'(goal_y) - 33'(ego_y);
	assign dz_in = 33'(goal_z) - 33'(ego_z);
	always_comb begin
		if (dz_in > 33'sd2147483647)
			dz_sat = 32'sh7FFFFFFF;
		else if (dz_in < -33'sd2147483648)
			dz_sat = 32'sh80000000;
		else
			dz_sat = dz_in[31:0];
	end

	logic fen, oen, accept, hold_v, hold_last;
	logic [IW-1:0] i_q;

	assign oen       = !m_tvalid || m_tready;
	assign hold_last = (i_q == n_eff - IW'(1));
	assign fen       = !hold_v || (oen && hold_last);
	assign s_tready  = fen;
	assign accept    = s_tvalid && s_tready;

	logic signed [TW-1:0] ce, se, cp, sp;

	efog_cordic u_cordic_ego (
		.clk   (clk),
		.en    (fen),
		.angle (ego_h),
		.cos_o (ce),
		.sin_o (se)
	);

	efog_cordic u_cordic_perp (
		.clk   (clk),
		.en    (fen),
		.angle (perp),
		.cos_o (cp),
		.sin_o (sp)
	);

	logic               v_s [0:L-1];
	logic signed [32:0] dx_s [0:L-1];
	logic signed [32:0] dy_s [0:L-1];
	logic signed [31:0] dz_s [0:L-1];
	logic [15:0]        rel_s [0:L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < L; k++)
				v_s[k] <= 1'b0;
		end else if (fen) begin
			v_s[0] <= accept && (n_eff != '0) && (spacing_q != '0);
			for (int k = 1; k < L; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			dx_s[0]  <= dx_in;
			dy_s[0]  <= dy_in;
			dz_s[0]  <= dz_sat;
			rel_s[0] <= rel;
			for (int k = 1; k < L; k++) begin
				dx_s[k]  <= dx_s[k-1];
				dy_s[k]  <= dy_s[k-1];
				dz_s[k]  <= dz_s[k-1];
				rel_s[k] <= rel_s[k-1];
			end
		end
	end

	logic                 v_m;
	logic signed [PW-1:0] p1_m, p2_m, p3_m, p4_m;
	logic signed [TW-1:0] cp_m, sp_m;
	logic signed [31:0]   dz_m;
	logic [15:0]          rel_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_m <= 1'b0;
		else if (fen)
			v_m <= v_s[L-1];
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			p1_m  <= PW'(ce * dx_s[L-1]);
			p2_m  <= PW'(se * dy_s[L-1]);
			p3_m  <= PW'(ce * dy_s[L-1]);
			p4_m  <= PW'(se * dx_s[L-1]);
			cp_m  <= cp;
			sp_m  <= sp;
			dz_m  <= dz_s[L-1];
			rel_m <= rel_s[L-1];
		end
	end

	logic signed [AW-1:0] rx_q, ry_q;
	logic signed [TW-1:0] cp_q, sp_q;
	logic signed [31:0]   dz_q;
	logic [15:0]          rel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v <= 1'b0;
			i_q    <= '0;
		end else if (fen) begin
			hold_v <= v_m;
			i_q    <= '0;
		end else if (oen) begin
			i_q <= i_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			rx_q  <= AW'(p1_m) + AW'(p2_m);
			ry_q  <= AW'(p3_m) - AW'(p4_m);
			cp_q  <= cp_m;
			sp_q  <= sp_m;
			dz_q  <= dz_m;
			rel_q <= rel_m;
		end
	end

	logic issue;
	assign issue = hold_v && oen;

	logic signed [IW:0]   lane;
	assign lane = $signed({1'b0, i_q}) - $signed({1'b0, half});

	logic                 v_e1, last_e1;
	logic [IW-1:0]        i_e1;
	logic signed [DW-1:0] d_e1;
	logic signed [AW-1:0] rx_e1, ry_e1;
	logic signed [TW-1:0] cp_e1, sp_e1;
	logic signed [31:0]   dz_e1;
	logic [15:0]          rel_e1;

	logic                 v_e2, last_e2;
	logic [IW-1:0]        i_e2;
	logic signed [AW-1:0] rx_e2, ry_e2, px_e2, py_e2;
	logic signed [31:0]   dz_e2;
	logic [15:0]          rel_e2;

	logic                 v_e3, last_e3;
	logic [IW-1:0]        i_e3;
	logic signed [31:0]   ox_e3, oy_e3, dz_e3;
	logic [15:0]          rel_e3;

	function automatic logic signed [31:0] round_sat(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] r;
		r = (a + (AW'(1) <<< 28)) >>> 29;
		if (r > AW'(64'sd2147483647))
			return 32'sh7FFFFFFF;
		else if (r < -AW'(64'sd2147483648))
			return 32'sh80000000;
		else
			return r[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
			v_e3 <= 1'b0;
		end else if (oen) begin
			v_e1 <= issue;
			v_e2 <= v_e1;
			v_e3 <= v_e2;
		end
	end

	always_ff @(posedge clk) begin
		if (oen) begin
			i_e1    <= i_q;
			last_e1 <= hold_last;
			d_e1    <= DW'(lane * $signed({1'b0, spacing_q}));
			rx_e1   <= rx_q;
			ry_e1   <= ry_q;
			cp_e1   <= cp_q;
			sp_e1   <= sp_q;
			dz_e1   <= dz_q;
			rel_e1  <= rel_q;

			i_e2    <= i_e1;
			last_e2 <= last_e1;
			px_e2   <= AW'(d_e1 * cp_e1);
			py_e2   <= AW'(d_e1 * sp_e1);
			rx_e2   <= rx_e1;
			ry_e2   <= ry_e1;
			dz_e2   <= dz_e1;
			rel_e2  <= rel_e1;

			i_e3    <= i_e2;
			last_e3 <= last_e2;
			ox_e3   <= round_sat(rx_e2 + px_e2);
			oy_e3   <= round_sat(ry_e2 + py_e2);
			dz_e3   <= dz_e2;
			rel_e3  <= rel_e2;
		end
	end

	assign m_tvalid = v_e3;
	assign m_tlast  = last_e3;
	assign m_tdata  = {4'b0, 4'(i_e3), rel_e3, dz_e3, oy_e3, ox_e3};

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v |-> (i_q < n_eff))
		else $error("sequencer index ran past the path count");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(v_e3 && last_e3) |-> (i_e3 == n_eff - IW'(1)))
		else $error("final item of a run carries the wrong index");

	a_hold_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_v && !oen) |=> (hold_v && $stable(i_q)))
		else $error("sequencer moved while the output was stalled");

endmodule

// File: verif/ego_frame_offset_goal_generator_tb.sv
// Self-checking testbench for the ego frame offset goal generator: directed poses,
// then random poses under changing registers and flow control on both streams.
// Depends on efog_pkg and the ego_frame_offset_goal_generator top level.
module ego_frame_offset_goal_generator_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = efog_pkg::CORDIC_LAT + 24;

	typedef struct packed {
		logic [31:0] offset_x;
		logic [31:0] offset_y;
		logic [31:0] offset_z;
		logic [15:0] offset_heading;
		logic [3:0]  goal_index;
		logic        last;
	} offset_goal_t;

	class goal_scoreboard;
		offset_goal_t goals_due[$];
		int unsigned  path_count;
		int unsigned  spacing;
		int           errors;
		int           inputs_seen;
		int           goals_seen;
		int           goalless_inputs;

		function new();
			path_count = efog_pkg::PATH_COUNT_RESET;
			spacing    = efog_pkg::SPACING_RESET;
		endfunction

		task report(input string msg);
			if (errors < 40)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function automatic longint clamp_trig(input longint v);
			if (v > 64'sd536870912)
				return 64'sd536870912;
			if (v < -64'sd536870912)
				return -64'sd536870912;
			return v;
		endfunction

		function automatic longint sat32(input longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function automatic void trig(input logic [15:0] ang, output longint c, output longint s);
			logic [15:0] a;
			logic [15:0] shifted;
			logic        flip;
			longint      x, y, z, xs, ys;
			longint      atans [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
				10, 5, 3, 1, 1};
			a = ang;
			shifted = a + 16'd16384;
			flip = shifted[15];
			if (flip)
				a = a ^ 16'h8000;
			x = 64'sd652032874;
			y = 0;
			z = longint'($signed(a));
			for (int i = 0; i < 15; i++) begin
				xs = y >>> i;
				ys = x >>> i;
				if (z >= 0) begin
					x = x - xs;
					y = y + ys;
					z = z - atans[i];
				end else begin
					x = x + xs;
					y = y - ys;
					z = z + atans[i];
				end
			end
			x = clamp_trig((x + 1) >>> 1);
			y = clamp_trig((y + 1) >>> 1);
			if (flip) begin
				x = -x;
				y = -y;
			end
			c = x;
			s = y;
		endfunction

		function void set_register(input logic idx, input logic [20:0] value);
			if (idx == efog_pkg::REG_PATH_COUNT)
				path_count = value[4:0];
			else
				spacing = value;
		endfunction

		function void note_pose(input logic [223:0] d);
			longint       dx, dy, dz, ce, se, cp, sp, rx, ry, half, lat_d, ax, ay;
			logic [15:0]  rel;
			int           n;
			offset_goal_t g;
			inputs_seen++;
			dx = longint'($signed(d[143:112])) - longint'($signed(d[31:0]));
			dy = longint'($signed(d[175:144])) - longint'($signed(d[63:32]));
			dz = sat32(longint'($signed(d[207:176])) - longint'($signed(d[95:64])));
			rel = d[223:208] - d[111:96];
			n = (path_count > 16) ? 16 : path_count;
			if (n == 0 || spacing == 0) begin
				goalless_inputs++;
				return;
			end
			trig(d[111:96], ce, se);
			rx = ce * dx + se * dy;
			ry = ce * dy - se * dx;
			trig(rel + 16'd16384, cp, sp);
			half = n / 2;
			for (int i = 0; i < n; i++) begin
				lat_d = (longint'(i) - half) * longint'(spacing);
				ax = rx + lat_d * cp;
				ay = ry + lat_d * sp;
				g.offset_x       = 32'(sat32((ax + (64'sd1 <<< 28)) >>> 29));
				g.offset_y       = 32'(sat32((ay + (64'sd1 <<< 28)) >>> 29));
				g.offset_z       = 32'(dz);
				g.offset_heading = rel;
				g.goal_index     = 4'(i);
				g.last           = (i == n - 1);
				goals_due = {goals_due, g};
			end
		endfunction

		task check_goal(input logic [119:0] d, input logic tl);
			offset_goal_t want;
			goals_seen++;
			if (goals_due.size() == 0) begin
				report($sformatf("unexpected goal %h last %b", d, tl));
				return;
			end
			want = goals_due.pop_front();
			if (d[31:0] !== want.offset_x)
				report($sformatf("offset_x %h, expected %h", d[31:0], want.offset_x));
			if (d[63:32] !== want.offset_y)
				report($sformatf("offset_y %h, expected %h", d[63:32], want.offset_y));
			if (d[95:64] !== want.offset_z)
				report($sformatf("offset_z %h, expected %h", d[95:64], want.offset_z));
			if (d[111:96] !== want.offset_heading)
				report($sformatf("offset_heading %h, expected %h", d[111:96],
					want.offset_heading));
			if (d[115:112] !== want.goal_index)
				report($sformatf("goal_index %0d, expected %0d", d[115:112], want.goal_index));
			if (d[119:116] !== 4'd0)
				report($sformatf("fill bits %h not zero", d[119:116]));
			if (tl !== want.last)
				report($sformatf("tlast %b, expected %b", tl, want.last));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [223:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;
	logic         m_tlast;
	logic         cfg_we;
	logic         cfg_index;
	logic [20:0]  cfg_wdata;

	goal_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;
	int hold_seen;
	int hold_left;
	int quiet_cycles;
	int settings_used;

	ego_frame_offset_goal_generator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// The receiver counts its own long hold-offs so the sender keeps pushing meanwhile.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= hold_req;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_pose(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_goal(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("ego_frame_offset_goal_generator_tb: FAIL");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	task automatic send_pose(input logic [223:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.goals_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [20:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, value);
		settings_used++;
	endtask

	task automatic set_config(input logic [20:0] count, input logic [20:0] spc);
		drain();
		write_reg(efog_pkg::REG_PATH_COUNT, count);
		write_reg(efog_pkg::REG_LATERAL_SPACING, spc);
	endtask

	function automatic logic [223:0] pose(input logic [31:0] ex, input logic [31:0] ey,
		input logic [31:0] ez, input logic [15:0] eh, input logic [31:0] gx,
		input logic [31:0] gy, input logic [31:0] gz, input logic [15:0] gh);
		return {gh, gz, gy, gx, eh, ez, ey, ex};
	endfunction

	function automatic logic [31:0] near(input logic [31:0] base);
		return base + {8'h00, 24'($urandom_range(32'hFFFFFF))} - 32'h800000;
	endfunction

	function automatic logic [223:0] random_pose();
		logic [31:0] ex, ey, ez;
		if ($urandom_range(99) < 30)
			return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		ex = $urandom >>> $urandom_range(14, 4);
		ey = $urandom >>> $urandom_range(14, 4);
		ez = $urandom >>> $urandom_range(16, 8);
		return pose(ex, ey, ez, 16'($urandom), near(ex), near(ey), near(ez), 16'($urandom));
	endfunction

	task automatic random_phase(input int items, input int sidle, input int ridle,
		input bit with_hold);
		int unsigned count;
		int unsigned spc;
		int          pick;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		for (int k = 0; k < items; k++) begin
			if (k % 25 == 0) begin
				pick = $urandom_range(9);
				count = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(31, 16) :
					(pick == 2) ? 1 : $urandom_range(8, 2);
				pick = $urandom_range(9);
				spc = (pick == 0) ? 1 : (pick == 1) ? 1048576 : (pick == 2) ? 21'h1FFFFF :
					(pick == 3) ? 0 : $urandom_range(262144, 1024);
				set_config(21'(count), 21'(spc));
			end
			if (with_hold && k == 40)
				hold_req++;
			send_pose(random_pose());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		hold_req = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		settings_used = 0;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed poses under the reset register values first.
		send_pose('0);
		send_pose(pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF,
			32'h80000000, 32'h80000000, 32'h80000000, 16'h8000));
		send_pose(pose(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF));
		send_pose(pose(0, 0, 0, 16'h4000, 32'h10000, 32'h20000, 0, 16'h0000));
		send_pose(pose(0, 0, 0, 16'hC000, 32'h10000, 32'h20000, 0, 16'h4000));
		send_pose(pose(32'h50000, 32'hFFFB0000, 0, 16'h2000, 32'h90000, 0, 32'h10000, 16'hE000));
		send_pose(pose({32{1'b1}}, {32{1'b1}}, {32{1'b1}}, 16'hFFFF, {32{1'b1}}, {32{1'b1}},
			{32{1'b1}}, 16'hFFFF));
		set_config(16, 1048576);
		send_pose(pose(0, 0, 0, 16'h8000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 16'h4000));
		send_pose(pose(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 16'h5555,
			32'hEDCBA987, 32'h6543210F, 32'hF0F0F0F0, 16'hAAAA));
		set_config(31, 21'h1FFFFF);
		send_pose(pose(0, 0, 0, 16'h0000, 32'h7FFFFFFF, 0, 0, 16'h0000));
		send_pose(pose(0, 0, 0, 16'h3FFF, 0, 32'h7FFFFFFF, 0, 16'hC000));
		set_config(1, 1);
		send_pose(pose(32'h10000, 32'h10000, 0, 16'h1000, 32'h30000, 32'hFFFF0000, 0, 16'h1000));
		send_pose(pose(0, 0, 0, 16'h8001, 32'hFFFF0000, 0, 0, 16'h7FFF));
		set_config(0, 65536);
		send_pose(pose(0, 0, 0, 0, 32'h10000, 0, 0, 0));
		send_pose(random_pose());
		set_config(5, 0);
		send_pose(pose(0, 0, 0, 0, 32'h10000, 0, 0, 0));
		send_pose(random_pose());
		set_config(2, 65536);
		send_pose(random_pose());
		send_pose(random_pose());

		random_phase(100, 10, 68, 1'b0);
		random_phase(100, 68, 10, 1'b0);
		random_phase(100, 0, 0, 1'b1);
		drain();

		while (sb.goals_due.size() > 0)
			sb.report($sformatf("goal %0d never arrived", sb.goals_due.pop_front().goal_index));
		$display("Covered %0d poses (%0d with no goals) and %0d offset goals", sb.inputs_seen,
			sb.goalless_inputs, sb.goals_seen);
		$display("over %0d register writes, with stalls on both streams and a long hold-off.",
			settings_used);
		if (sb.errors == 0) begin
			$display("ego_frame_offset_goal_generator_tb: PASS");
		end else begin
			$display("ego_frame_offset_goal_generator_tb: FAIL");
		end
		$finish;
	end

endmodule
